// ===== rtl/core/bprs_pkg.sv =====
// Shared constants, register codes and cell control type of the byte pattern replacer.
package bprs_pkg;

  // Longest pattern the window can hold, and bytes carried by the pattern registers.
  localparam int MAX_PATTERN_BYTES = 8;
  localparam int REG_BYTES         = 8;
  localparam int MAX_LEN = (MAX_PATTERN_BYTES < REG_BYTES) ? MAX_PATTERN_BYTES : REG_BYTES;

  // Field and register widths.
  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 32;
  localparam int REG_W      = 64;
  localparam int LEN_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int OUT_DATA_W = BYTE_W + COUNT_W;

  // Window occupancy, cooldown and effective length share this width.
  localparam int NUM_CELLS = MAX_PATTERN_BYTES;
  localparam int FILL_W    = $clog2(MAX_PATTERN_BYTES + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN = 2'd0,
    REG_REPLACE = 2'd1,
    REG_LENGTH  = 2'd2
  } cfg_reg_t;

  // Per-cell control from the window controller.
  typedef struct packed {
    logic step;     // the window advances this cycle
    logic load;     // the incoming byte lands in this cell
    logic in_use;   // this cell lies inside the active pattern length
    logic replace;  // the window matched and takes the replacement
    logic shift;    // the oldest byte leaves, every cell takes its neighbor's byte
  } cell_ctrl_t;

endpackage

// ===== rtl/core/bprs_cell.sv =====
// One window cell: holds a byte, compares it with its pattern byte and hands it to its neighbor.
module bprs_cell (
  input  logic                       clk,
  input  bprs_pkg::cell_ctrl_t       ctrl,
  input  logic [bprs_pkg::BYTE_W-1:0] in_byte,
  input  logic [bprs_pkg::BYTE_W-1:0] pat_byte,
  input  logic [bprs_pkg::BYTE_W-1:0] rep_byte,
  input  logic [bprs_pkg::BYTE_W-1:0] from_next,
  output logic [bprs_pkg::BYTE_W-1:0] post_byte,
  output logic                       match_ok
);
  import bprs_pkg::*;

  logic [BYTE_W-1:0] stored;
  logic [BYTE_W-1:0] win_byte;

  // Window content after the incoming byte is appended.
  assign win_byte = ctrl.load ? in_byte : stored;

  // Cells beyond the pattern length never block a match.
  assign match_ok = !ctrl.in_use || (win_byte == pat_byte);

  // Content after a possible replacement; this is what moves toward the output.
  assign post_byte = (ctrl.replace && ctrl.in_use) ? rep_byte : win_byte;

  // Hold or shift toward the oldest end.
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      stored <= ctrl.shift ? from_next : post_byte;
    end
  end

endmodule

// ===== rtl/core/byte_pattern_replace_stream.sv =====
// Top level of the streaming byte pattern replacer: configuration, cell chain and control.
//
// Usage: bytes enter on the s_ side (tdata = byte, tlast = end of buffer) and leave on
// the m_ side in the same order, each either unchanged or overwritten by the replacement
// when it belongs to a leftmost, non-overlapping occurrence of the pattern. The item that
// carries m_tlast also carries the replacement count of the buffer in m_tdata[39:8]; that
// field is zero on every other item. Pattern, replacement and length are written through
// the cfg_ channel (index 0, 1, 2); the user writes them only while the stream is idle
// (the block does not enforce this), and cfg_ready is always high. With pattern length
// L > 0 a byte enters the output register with the item that makes the window hold L
// bytes, i.e. L-1 items after it arrived; with L = 0 it enters with its own item. While
// s_tready is high one item is taken per cycle; all cells do the window compare in
// parallel in the same cycle as the append. An item that closes a buffer, or the first
// item after the length was shortened, releases its pending bytes one by one with
// s_tready low. The output register may hold one item while the next item is taken;
// when the receiver stalls with that register full, s_tready drops in the same cycle.
// A synchronous reset zeroes config and control state, empties the window and drops m_tvalid.
module byte_pattern_replace_stream (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bprs_pkg::BYTE_W-1:0]     s_tdata,    // [7:0] in_byte
  input  logic                           s_tlast,    // in_last
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bprs_pkg::OUT_DATA_W-1:0] m_tdata,    // [7:0] out_byte, [39:8] replaced_total
  output logic                           m_tlast,    // out_last
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bprs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bprs_pkg::REG_W-1:0]      cfg_data
);
  import bprs_pkg::*;

  // Configuration registers.
  logic [REG_W-1:0] pattern_bytes;
  logic [REG_W-1:0] replacement_bytes;
  logic [LEN_W-1:0] pattern_length;

  // Window control state.
  logic              busy;
  logic              hold_last;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] cooldown;
  logic [COUNT_W-1:0] match_count;

  // Output register.
  logic [BYTE_W-1:0]  out_byte;
  logic [COUNT_W-1:0] out_total;

  // Control signals of the current cycle.
  logic              can_emit;
  logic              step;
  logic              cur_last;
  logic [FILL_W-1:0] len;
  logic [FILL_W-1:0] wfill;
  logic [FILL_W-1:0] fill_after;
  logic [FILL_W-1:0] cd_lim;
  logic [FILL_W-1:0] cooldown_next;
  logic [COUNT_W-1:0] count_next;
  logic              cmp_slot;
  logic              hit;
  logic              pop;
  logic              done;
  logic              fin;

  // Cell chain wiring.
  cell_ctrl_t              ctrl [NUM_CELLS];
  logic [BYTE_W-1:0]       chain_byte [NUM_CELLS+1];
  logic [NUM_CELLS-1:0]    match_ok;

  // Configuration writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes     <= '0;
      replacement_bytes <= '0;
      pattern_length    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN: pattern_bytes     <= cfg_data;
        REG_REPLACE: replacement_bytes <= cfg_data;
        REG_LENGTH:  pattern_length    <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective pattern length, saturated at what the window and registers hold.
  assign len = (pattern_length > LEN_W'(MAX_LEN)) ? FILL_W'(MAX_LEN) : FILL_W'(pattern_length);

  // Handshake: the window advances when the output register can take a byte.
  assign can_emit = !m_tvalid || m_tready;
  assign s_tready = !busy && can_emit;
  assign step     = can_emit && (busy || s_tvalid);
  assign cur_last = busy ? hold_last : s_tlast;

  // Window decisions for this cycle.
  always_comb begin
    wfill    = busy ? fill : fill + FILL_W'(1);
    cd_lim   = (cooldown > len - FILL_W'(1)) ? len - FILL_W'(1) : cooldown;
    cmp_slot = (len != '0) && (wfill == len);
    hit      = cmp_slot && (cd_lim == '0) && (&match_ok);
    pop      = cmp_slot ||
               ((wfill != '0) && ((len == '0) || (wfill > len) || (cur_last && (wfill < len))));
    fill_after = pop ? wfill - FILL_W'(1) : wfill;
    done     = cur_last ? (fill_after == '0) : ((fill_after < len) || (fill_after == '0));
    fin      = pop && cur_last && (fill_after == '0);
    count_next = (hit && (match_count != '1)) ? match_count + COUNT_W'(1) : match_count;
    if (len == '0) begin
      cooldown_next = '0;
    end else if (cmp_slot) begin
      if (hit) begin
        cooldown_next = len - FILL_W'(1);
      end else if (cd_lim != '0) begin
        cooldown_next = cd_lim - FILL_W'(1);
      end else begin
        cooldown_next = '0;
      end
    end else begin
      cooldown_next = cooldown;
    end
  end

  // Window control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      hold_last   <= 1'b0;
      fill        <= '0;
      cooldown    <= '0;
      match_count <= '0;
    end else if (step) begin
      fill <= fill_after;
      busy <= !done;
      if (!busy) begin
        hold_last <= s_tlast;
      end
      if (done && cur_last) begin
        cooldown    <= '0;
        match_count <= '0;
      end else begin
        cooldown    <= cooldown_next;
        match_count <= count_next;
      end
    end
  end

  // Row of window cells, oldest byte in cell zero.
  assign chain_byte[NUM_CELLS] = '0;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    assign ctrl[g] = '{step:    step,
                       load:    !busy && (fill == FILL_W'(g)),
                       in_use:  FILL_W'(g) < len,
                       replace: hit,
                       shift:   pop};

    bprs_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[g]),
      .in_byte   (s_tdata),
      .pat_byte  (pattern_bytes[BYTE_W*(g % REG_BYTES) +: BYTE_W]),
      .rep_byte  (replacement_bytes[BYTE_W*(g % REG_BYTES) +: BYTE_W]),
      .from_next (chain_byte[g+1]),
      .post_byte (chain_byte[g]),
      .match_ok  (match_ok[g])
    );
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload: the oldest byte, with the count on the final item.
  always_ff @(posedge clk) begin
    if (step && pop) begin
      out_byte  <= chain_byte[0];
      m_tlast   <= fin;
      out_total <= fin ? count_next : '0;
    end
  end

  assign m_tdata = {out_total, out_byte};

endmodule

// ===== rtl/core/bprs_checker.sv =====
// Port-level checks of the byte pattern replacer and their attachment to the top level.
module bprs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [bprs_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);
  import bprs_pkg::*;

  // The count field is zero on every item that does not close a buffer.
  a_total_only_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[OUT_DATA_W-1:BYTE_W] == '0))
    else $error("replacement count shown on an item that is not the last");

  // Nothing is offered in the cycle after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // A stalled full output register blocks new input items.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while the output register is stalled");

  // A stalled output item holds its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output item changed");

endmodule

bind byte_pattern_replace_stream bprs_checker u_bprs_checker (.*);

// ===== dv/byte_pattern_replace_stream_test.sv =====
// Self-checking testbench for the streaming byte pattern replacer.
`timescale 1ns / 100ps

module byte_pattern_replace_stream_test;
  import bprs_pkg::*;

  // Cycles the block may still need after its last expected item has left.
  localparam int SETTLE_CYCLES = 2 * MAX_PATTERN_BYTES + 4;
  localparam int RANDOM_ITEMS  = 420;
  localparam int HOLD_CYCLES   = 250;
  // Register index that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  // One item as it should leave the block.
  typedef struct {
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic [COUNT_W-1:0] total;
  } out_item_t;

  // Shadow of the replacer: tracks registers and window, queues the bytes it must emit.
  class replace_scoreboard;
    logic [REG_W-1:0]   pattern_reg = '0;
    logic [REG_W-1:0]   replace_reg = '0;
    logic [LEN_W-1:0]   length_reg  = '0;
    logic [BYTE_W-1:0]  window[MAX_PATTERN_BYTES];
    int unsigned        fill     = 0;
    int unsigned        cooldown = 0;
    logic [COUNT_W-1:0] hits     = '0;
    out_item_t          expected_bytes[$];
    int                 mismatch_count = 0;

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] d);
      case (idx)
        REG_PATTERN: pattern_reg = d;
        REG_REPLACE: replace_reg = d;
        REG_LENGTH:  length_reg  = d[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Removes the oldest pending byte and queues it as an ordinary output.
    function void release_oldest(ref out_item_t step_out[$]);
      out_item_t it;
      it.data  = window[0];
      it.last  = 1'b0;
      it.total = '0;
      for (int i = 1; i < fill; i++) window[i-1] = window[i];
      if (fill > 0) fill--;
      step_out.push_back(it);
    endfunction

    // Works out the bytes released by one accepted input item.
    function void note_byte(logic [BYTE_W-1:0] b, logic l);
      out_item_t   step_out[$];
      out_item_t   tail;
      int unsigned len;
      bit          hit;
      len = (length_reg > MAX_LEN) ? MAX_LEN : length_reg;
      if (fill < MAX_PATTERN_BYTES) begin
        window[fill] = b;
        fill++;
      end
      if (len == 0) begin
        while (fill > 0) release_oldest(step_out);
        cooldown = 0;
      end else begin
        while (fill > len) release_oldest(step_out);
        if (fill == len) begin
          if (cooldown > len - 1) cooldown = len - 1;
          if (cooldown > 0) begin
            cooldown--;
          end else begin
            hit = 1'b1;
            for (int i = 0; i < len; i++)
              if (window[i] != pattern_reg[8*i +: 8]) hit = 1'b0;
            if (hit) begin
              for (int i = 0; i < len; i++) window[i] = replace_reg[8*i +: 8];
              if (hits != '1) hits++;
              cooldown = len - 1;
            end
          end
          release_oldest(step_out);
        end
      end
      // The end of a buffer flushes the window and reports the count.
      if (l) begin
        while (fill > 0) release_oldest(step_out);
        if (step_out.size() > 0) begin
          tail = step_out.pop_back();
          tail.last  = 1'b1;
          tail.total = hits;
          step_out.push_back(tail);
        end
        fill     = 0;
        cooldown = 0;
        hits     = '0;
      end
      foreach (step_out[i]) expected_bytes.push_back(step_out[i]);
    endfunction

    function void report(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
    endfunction

    // Compares one accepted output item with the oldest expected one.
    function void check_byte(logic [BYTE_W-1:0] b, logic l, logic [COUNT_W-1:0] total);
      out_item_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected item: byte %02h last %0b total %0d", b, l, total));
        return;
      end
      want = expected_bytes.pop_front();
      if (want.data !== b || want.last !== l || want.total !== total)
        report($sformatf("mismatch: expected byte %02h last %0b total %0d, got byte %02h last %0b total %0d",
                         want.data, want.last, want.total, b, l, total));
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata;     // [7:0] in_byte
  logic                  s_tlast;     // in_last
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;     // [7:0] out_byte, [39:8] replaced_total
  logic                  m_tlast;     // out_last
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [REG_W-1:0]      cfg_data;

  replace_scoreboard sb;
  int                tx_idle_pct = 29;
  int                rx_idle_pct = 64;
  int                items_sent  = 0;
  bit                hold_armed  = 1'b0;
  int unsigned       cur_len     = 0;

  byte_pattern_replace_stream u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("byte_pattern_replace_stream_test failed");
    $finish;
  end

  // Receiver: checks accepted items, stalls at random and once holds off for a long stretch.
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        sb.check_byte(m_tdata[BYTE_W-1:0], m_tlast, m_tdata[BYTE_W +: COUNT_W]);
      if (hold_armed && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offers one byte after a random gap and waits until the block takes it.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic l);
    if (items_sent < 150) begin
      tx_idle_pct = 29;
      rx_idle_pct = 64;
    end else if (items_sent < 300) begin
      tx_idle_pct = 64;
      rx_idle_pct = 29;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b, l);
    items_sent++;
  endtask

  // Stops offering and waits until every expected item is out and the block has settled.
  task automatic drain_stream();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register; the caller lowers cfg_valid after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, d);
  endtask

  // Length value with random upper bits, which the block must ignore.
  function automatic logic [REG_W-1:0] length_word(int unsigned l);
    logic [REG_W-1:0] w;
    w = {$urandom, $urandom};
    w[LEN_W-1:0] = l[LEN_W-1:0];
    return w;
  endfunction

  task automatic configure(input logic [REG_W-1:0] pat, input logic [REG_W-1:0] rep,
                           input int unsigned l);
    write_reg(REG_PATTERN, pat);
    write_reg(REG_REPLACE, rep);
    write_reg(REG_LENGTH, length_word(l));
    cfg_valid <= 1'b0;
    cur_len = l;
  endtask

  task automatic send_run(input byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte(logic [REG_W-1:0] pat, int unsigned len);
    if (len > 0 && $urandom_range(0, 1) == 0) return pat[8*$urandom_range(0, len - 1) +: 8];
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Builds one buffer: mostly occurrences, prefixes and near misses of the pattern.
  function automatic void build_buffer(ref byte_q_t q, input logic [REG_W-1:0] pat,
                                       input int unsigned len);
    int          pieces;
    int unsigned kind;
    int unsigned k;
    int unsigned flip;
    bit          noise;
    q.delete();
    noise  = (len == 0) || ($urandom_range(0, 6) == 0);
    pieces = $urandom_range(1, 4);
    for (int p = 0; p < pieces; p++) begin
      kind = $urandom_range(0, 9);
      if (noise || kind < 3) begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) q.push_back(pick_byte(pat, len));
      end else if (kind < 7) begin
        for (int i = 0; i < len; i++) q.push_back(pat[8*i +: 8]);
      end else if (kind < 9) begin
        // A partial start right before a full occurrence tests the leftmost rule.
        k = (len > 1) ? $urandom_range(1, len - 1) : 0;
        for (int i = 0; i < k; i++) q.push_back(pat[8*i +: 8]);
        for (int i = 0; i < len; i++) q.push_back(pat[8*i +: 8]);
      end else begin
        flip = $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++)
          q.push_back(pat[8*i +: 8] ^ ((i == flip) ? 8'h01 << $urandom_range(0, 7) : 8'h00));
      end
    end
  endfunction

  function automatic logic [BYTE_W-1:0] edge_or_random();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Main sequence: reset, directed cases, then random phases of settings and buffers.
  initial begin
    byte_q_t          q;
    byte_q_t          rest;
    logic [REG_W-1:0] pat;
    logic [REG_W-1:0] rep;
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] y;
    int unsigned      l;
    int unsigned      eff;
    int               phase;
    int               nbuf;
    int               split;
    int               random_target;

    sb = new();
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_PATTERN;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers at reset: length zero passes bytes straight through.
    send_run('{8'h00, 8'hFF});
    drain_stream();

    // Single-byte pattern: every matching byte is replaced, also a one-byte buffer.
    write_reg(REG_SPARE, {$urandom, $urandom});
    configure('1, '0, 1);
    send_run('{8'hFF, 8'h00, 8'hFF, 8'hFF});
    send_run('{8'hFF});
    drain_stream();

    // Longest pattern: an exact occurrence, then a short buffer flushed early.
    configure(64'h0706_0504_0302_0100, {$urandom, $urandom}, 8);
    send_run('{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07});
    send_run('{8'h00, 8'h01, 8'h02});
    drain_stream();

    // Repeated byte: overlapping occurrences count only once per three bytes.
    configure({8{8'hAA}}, {$urandom, $urandom}, 3);
    send_run('{8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA});
    drain_stream();

    // Random phases; the first ones walk through the length extremes.
    random_target = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < random_target) begin
      case (phase)
        0: l = 15;
        1: l = 0;
        2: l = 8;
        3: l = 1;
        default: begin
          case ($urandom_range(0, 9))
            0:       l = 0;
            1:       l = 8;
            2:       l = $urandom_range(9, 15);
            default: l = $urandom_range(1, 7);
          endcase
        end
      endcase
      x = edge_or_random();
      y = edge_or_random();
      case ($urandom_range(0, 2))
        0:       pat = {$urandom, $urandom};
        1:       pat = {8{x}};
        default: pat = {4{y, x}};
      endcase
      case ($urandom_range(0, 5))
        0:       rep = '0;
        1:       rep = '1;
        default: rep = {$urandom, $urandom};
      endcase
      configure(pat, rep, l);

      nbuf = $urandom_range(3, 8);
      for (int bi = 0; bi < nbuf && items_sent < random_target; bi++) begin
        if (items_sent >= random_target - 100) hold_armed = 1'b1;
        eff = (cur_len > MAX_LEN) ? MAX_LEN : cur_len;
        build_buffer(q, pat, eff);
        split = q.size();
        if (q.size() >= 2 && $urandom_range(0, 5) == 0) split = $urandom_range(1, q.size() - 1);
        if (split == q.size()) begin
          send_run(q);
        end else begin
          // Length change in the middle of a buffer, with bytes still pending.
          for (int i = 0; i < split; i++) send_byte(q[i], 1'b0);
          drain_stream();
          cur_len = $urandom_range(0, 15);
          write_reg(REG_LENGTH, length_word(cur_len));
          cfg_valid <= 1'b0;
          rest.delete();
          for (int i = split; i < q.size(); i++) rest.push_back(q[i]);
          send_run(rest);
        end
      end
      drain_stream();
      phase++;
    end

    drain_stream();
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("byte_pattern_replace_stream_test passed");
    end else begin
      $display("byte_pattern_replace_stream_test failed");
    end
    $finish;
  end

endmodule
